>>> rtl/skh_pkg.sv
// ----------------------------------------------------------------------------
// skh_pkg
// Shared types and codes for the string-keyed hash table.
// ----------------------------------------------------------------------------
package skh_pkg;

    localparam logic [63:0] HASH_START = 64'd5381;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] key_byte;
        logic       last_byte;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] slot_index;
    } rsp_t;

endpackage

>>> rtl/string_key_hash_table.sv
// ----------------------------------------------------------------------------
// string_key_hash_table
// djb2-hashed open-addressed table of byte-string keys, quadratic probing.
// ----------------------------------------------------------------------------
// Non-final key bytes: one per cycle, back to back.
// Final byte: hash reduction, then S_PADDR and S_PCHK per probe, S_CMPRD and S_CMPCK
// per key byte compared (lookup) or S_CPRD and S_CPWR per byte copied (insert), and
// S_DONE to load the result register. Too-long and table-full answers go straight
// from the final byte to S_DONE. After reset a clearing pass empties the slot table;
// no beat is taken until it ends.
module string_key_hash_table
    import skh_pkg::*;
#(
    parameter int TABLE_SLOTS = 127,
    parameter int KEY_BYTES   = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);
    localparam int SW   = $clog2(TABLE_SLOTS);
    localparam int PW   = $clog2(TABLE_SLOTS + 1);
    localparam int LW   = $clog2(KEY_BYTES + 1);
    localparam int IW   = $clog2(KEY_BYTES);
    localparam int QW   = 2 * SW;
    localparam int HALF = TABLE_SLOTS / 2;

    function automatic int pow2_64_mod(input int n);
        int r;
        r = 1;
        for (int k = 0; k < 64; k++)
        begin
            r = 2 * r;
            if (r >= n)
            begin
                r = r - n;
            end
        end
        return r;
    endfunction

    localparam int WRAP_MOD = pow2_64_mod(TABLE_SLOTS);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_PADDR = 4'd3;
    localparam logic [3:0] S_PCHK  = 4'd4;
    localparam logic [3:0] S_CMPRD = 4'd5;
    localparam logic [3:0] S_CMPCK = 4'd6;
    localparam logic [3:0] S_CPRD  = 4'd7;
    localparam logic [3:0] S_CPWR  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [63:0]   hash_reg, hash_next;
    logic [LW-1:0] klen_reg, klen_next;
    logic          cmd_reg, cmd_next;
    logic [PW-1:0] count_reg, count_next;
    logic [SW-1:0] clr_reg, clr_next;
    logic [SW-1:0] base_reg, base_next;
    logic [PW-1:0] p_reg, p_next;
    logic [SW-1:0] pm_reg, pm_next;
    logic [SW-1:0] dm_reg, dm_next;
    logic [QW-1:0] psq_reg, psq_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [2:0]    res_status_reg, res_status_next;
    logic [SW-1:0] res_slot_reg, res_slot_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    // memories
    logic [7:0]    key_buf_mem [KEY_BYTES];
    logic [7:0]    key_mem [2**(SW+IW)];
    logic [LW:0]   meta_mem [TABLE_SLOTS];
    logic [7:0]    kb_q, km_q;
    logic [LW:0]   meta_q;

    logic          req_fire;
    logic [63:0]   hash_upd;
    logic [LW-1:0] klen_upd;
    logic          buf_wr;
    logic          mod_done;
    logic          mod_kick_reg;
    logic [SW-1:0] mod_rem;
    logic [SW:0]   sum_a;
    logic [SW-1:0] slot_a, probe_slot;
    logic [QW:0]   low_sum;
    logic          wrap;
    logic          step;
    logic          km_wr;
    logic          meta_wr;
    logic [SW-1:0] meta_wr_addr;
    logic [LW:0]   meta_wr_data;
    logic          idx_last;

    assign req_fire = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);

    assign hash_upd = (hash_reg << 5) + hash_reg + {56'd0, req.key_byte};
    assign buf_wr   = req_fire && (klen_reg < LW'(KEY_BYTES - 1));
    assign klen_upd = buf_wr ? klen_reg + LW'(1) : LW'(KEY_BYTES);

    skh_hash_mod #(.MODULUS(TABLE_SLOTS)) u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_kick_reg),
        .value     (hash_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // probe slot = (hash + p*p) mod 2^64 mod N, with p*p tracked mod N
    always_comb
    begin
        sum_a = {1'b0, base_reg} + {1'b0, pm_reg};
        if (sum_a >= (SW+1)'(TABLE_SLOTS))
        begin
            slot_a = SW'(sum_a - (SW+1)'(TABLE_SLOTS));
        end
        else
        begin
            slot_a = sum_a[SW-1:0];
        end
        low_sum = {1'b0, hash_reg[QW-1:0]} + {1'b0, psq_reg};
        wrap = (&hash_reg[63:QW]) && low_sum[QW];
        if (!wrap)
        begin
            probe_slot = slot_a;
        end
        else if (slot_a >= SW'(WRAP_MOD))
        begin
            probe_slot = slot_a - SW'(WRAP_MOD);
        end
        else
        begin
            probe_slot = SW'((SW+1)'(slot_a) + (SW+1)'(TABLE_SLOTS)
                             - (SW+1)'(WRAP_MOD));
        end
    end

    assign idx_last = ((LW'(idx_reg) + LW'(1)) == klen_reg);

    always_comb
    begin
        logic [SW:0] pm_sum;
        logic [SW:0] dm_sum;
        state_next      = state_reg;
        hash_next       = hash_reg;
        klen_next       = klen_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        clr_next        = clr_reg;
        base_next       = base_reg;
        p_next          = p_reg;
        pm_next         = pm_reg;
        dm_next         = dm_reg;
        psq_next        = psq_reg;
        slot_next       = slot_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        km_wr           = 1'b0;
        meta_wr         = 1'b0;
        meta_wr_addr    = slot_reg;
        meta_wr_data    = {1'b1, klen_reg};
        step            = 1'b0;

        pm_sum = {1'b0, pm_reg} + {1'b0, dm_reg};
        dm_sum = {1'b0, dm_reg} + (SW+1)'(2);

        unique case (state_reg)
            S_CLEAR:
            begin
                meta_wr      = 1'b1;
                meta_wr_addr = clr_reg;
                meta_wr_data = '0;
                clr_next     = clr_reg + SW'(1);
                if (clr_reg == SW'(TABLE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    hash_next = hash_upd;
                    klen_next = klen_upd;
                    cmd_next  = req.command;
                    if (req.last_byte)
                    begin
                        res_slot_next = '0;
                        if (klen_upd > LW'(KEY_BYTES - 1))
                        begin
                            res_status_next = ST_TOO_LONG;
                            state_next      = S_DONE;
                        end
                        else if (req.command == CMD_INSERT && count_reg >= PW'(HALF))
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_MOD;
                        end
                    end
                end
            end
            S_MOD:
            begin
                // hash_reg is final by now; the reducer is kicked on entry
                if (mod_done)
                begin
                    base_next  = mod_rem;
                    p_next     = '0;
                    pm_next    = '0;
                    dm_next    = SW'(1);
                    psq_next   = '0;
                    state_next = S_PADDR;
                end
            end
            S_PADDR:
            begin
                slot_next  = probe_slot;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                idx_next = '0;
                if (!meta_q[LW])
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        state_next = S_CPRD;
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                        res_slot_next   = '0;
                        state_next      = S_DONE;
                    end
                end
                else if (cmd_reg == CMD_LOOKUP && meta_q[LW-1:0] == klen_reg)
                begin
                    state_next = S_CMPRD;
                end
                else
                begin
                    step = 1'b1;
                end
            end
            S_CMPRD:
            begin
                state_next = S_CMPCK;
            end
            S_CMPCK:
            begin
                if (kb_q != km_q)
                begin
                    step = 1'b1;
                end
                else if (idx_last)
                begin
                    res_status_next = ST_FOUND;
                    res_slot_next   = slot_reg;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_CMPRD;
                end
            end
            S_CPRD:
            begin
                state_next = S_CPWR;
            end
            S_CPWR:
            begin
                km_wr = 1'b1;
                if (idx_last)
                begin
                    meta_wr         = 1'b1;
                    count_next      = count_reg + PW'(1);
                    res_status_next = ST_INSERTED;
                    res_slot_next   = slot_reg;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_CPRD;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.status     = res_status_reg;
                    rsp_next.slot_index = 7'(res_slot_reg);
                    hash_next         = HASH_START;
                    klen_next         = '0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // advance to the next probe offset
        if (step)
        begin
            p_next   = p_reg + PW'(1);
            psq_next = psq_reg + QW'({p_reg, 1'b1});
            pm_next  = (pm_sum >= (SW+1)'(TABLE_SLOTS))
                       ? SW'(pm_sum - (SW+1)'(TABLE_SLOTS)) : pm_sum[SW-1:0];
            dm_next  = (dm_sum >= (SW+1)'(TABLE_SLOTS))
                       ? SW'(dm_sum - (SW+1)'(TABLE_SLOTS)) : dm_sum[SW-1:0];
            if (p_reg == PW'(TABLE_SLOTS - 1))
            begin
                res_status_next = (cmd_reg == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
                res_slot_next   = '0;
                state_next      = S_DONE;
            end
            else
            begin
                state_next = S_PADDR;
            end
        end
    end

    // the reducer starts the cycle after the final byte, once hash_reg holds it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            hash_reg      <= HASH_START;
            klen_reg      <= '0;
            count_reg     <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            mod_kick_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            klen_reg      <= klen_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
            mod_kick_reg  <= (state_reg == S_IDLE) && (state_next == S_MOD);
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        base_reg       <= base_next;
        p_reg          <= p_next;
        pm_reg         <= pm_next;
        dm_reg         <= dm_next;
        psq_reg        <= psq_next;
        slot_reg       <= slot_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        rsp_reg        <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (buf_wr)
        begin
            key_buf_mem[klen_reg[IW-1:0]] <= req.key_byte;
        end
        kb_q <= key_buf_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (km_wr)
        begin
            key_mem[{slot_reg, idx_reg}] <= kb_q;
        end
        km_q <= key_mem[{slot_reg, idx_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (meta_wr)
        begin
            meta_mem[meta_wr_addr] <= meta_wr_data;
        end
        meta_q <= meta_mem[probe_slot];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // table never holds more than half its slots
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= PW'(HALF))
        else $error("entry count above half the table");

    // a held response must not change
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // only legal status codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == ST_INSERTED || rsp.status == ST_FOUND ||
                       rsp.status == ST_NOT_FOUND || rsp.status == ST_FULL ||
                       rsp.status == ST_TOO_LONG))
        else $error("bad status code");

    // slot index is zero unless a slot was written or matched
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_INSERTED && rsp.status != ST_FOUND
        |-> rsp.slot_index == 7'd0)
        else $error("slot index set on a miss");

endmodule

>>> rtl/skh_hash_mod.sv
// ----------------------------------------------------------------------------
// skh_hash_mod
// Reduction of a 64-bit hash modulo the table size, four bits a cycle.
// ----------------------------------------------------------------------------
module skh_hash_mod
#(
    parameter int MODULUS = 127
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [63:0]                   value,
    output logic                          done,
    output logic [$clog2(MODULUS)-1:0]    remainder
);
    localparam int RW   = $clog2(MODULUS);
    localparam int SUMW = RW + 3;
    localparam int NIB  = 4;

    // weight of hash bit i is 2^i mod MODULUS
    function automatic logic [64*RW-1:0] build_weights();
        logic [64*RW-1:0] t;
        int               w;
        t = '0;
        w = 1 % MODULUS;
        for (int i = 0; i < 64; i++)
        begin
            t[i*RW +: RW] = RW'(w);
            w = (2 * w) % MODULUS;
        end
        return t;
    endfunction

    localparam logic [64*RW-1:0] WEIGHTS = build_weights();

    logic [63:0]     val_reg;
    logic [4:0]      cnt_reg;
    logic [RW-1:0]   rem_reg;
    logic            done_reg;
    logic [4:0]      chunk;
    logic [5:0]      wbase;
    logic [SUMW-1:0] acc;
    logic [SUMW-1:0] r1;
    logic [SUMW-1:0] r2;
    logic [RW-1:0]   reduced;

    // top nibble of val_reg holds hash bits 4*(cnt-1) .. 4*(cnt-1)+3
    always_comb
    begin
        chunk = cnt_reg - 5'd1;
        wbase = {chunk[3:0], 2'b00};
        acc   = SUMW'(rem_reg);
        for (int j = 0; j < NIB; j++)
        begin
            if (val_reg[60 + j])
            begin
                acc = acc + SUMW'(WEIGHTS[(int'(wbase) + j) * RW +: RW]);
            end
        end
        // acc < 5*MODULUS
        r1 = (acc >= SUMW'(4 * MODULUS)) ? acc - SUMW'(4 * MODULUS) : acc;
        r2 = (r1 >= SUMW'(2 * MODULUS)) ? r1 - SUMW'(2 * MODULUS) : r1;
        if (r2 >= SUMW'(MODULUS))
        begin
            reduced = RW'(r2 - SUMW'(MODULUS));
        end
        else
        begin
            reduced = r2[RW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= 5'd16;
            end
            else if (cnt_reg != 5'd0)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= value;
            rem_reg <= '0;
        end
        else if (cnt_reg != 5'd0)
        begin
            val_reg <= {val_reg[59:0], 4'b0000};
            rem_reg <= reduced;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
